[sv/ssfc_pkg.sv]
package ssfc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned TDATA_W = 40;

  // Fixed part of a frame: two header bytes, id, length
  localparam logic [POS_W-1:0]  FIXED_LEN     = 9'd4;
  localparam logic [POS_W-1:0]  POS_ID        = 9'd2;
  localparam logic [POS_W-1:0]  POS_LENGTH    = 9'd3;
  localparam logic [BYTE_W-1:0] CHECKSUM_FLAG = 8'h10;

  // Master tdata layout
  localparam int unsigned DATA_LSB  = 0;
  localparam int unsigned INDEX_LSB = 8;
  localparam int unsigned ID_LSB    = 17;
  localparam int unsigned FLAGS_LSB = 25;
  localparam int unsigned PAD_LSB   = 33;

endpackage

[sv/servo_status_frame_checker.sv]
// An accepted byte's result is registered and reaches the master side in the next cycle.
// Throughput: one byte per cycle unless the master side stalls; the frame
// state and the result register update together on each accepted request,
// and s_axis_tready is high whenever the result register is empty or draining.
// Reset: rst (synchronous) clears the frame position, the stored length, id,
// error byte and running sum, and drops m_axis_tvalid.
module servo_status_frame_checker
  import ssfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // data_byte [7:0], byte_index [16:8], frame_id [24:17], status_flags [32:25], zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast,   // frame_last
  output logic [0:0]         m_axis_tuser    // checksum_bad
);

  logic [POS_W-1:0]  position, position_next;
  logic [BYTE_W-1:0] body_length, body_length_next;
  logic [BYTE_W-1:0] device_id, device_id_next;
  logic [BYTE_W-1:0] error_byte, error_byte_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;

  logic              s_fire;
  logic              last_c;
  logic              bad_c;
  logic [BYTE_W-1:0] flags_c;
  logic [BYTE_W-1:0] id_c;
  logic [POS_W-1:0]  last_pos;

  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_index;
  logic [BYTE_W-1:0] out_id;
  logic [BYTE_W-1:0] out_flags;
  logic              out_last;
  logic              out_bad;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Checksum sits at position length + 3
  assign last_pos = {1'b0, body_length} + FIXED_LEN - 9'd1;

  always_comb begin
    body_length_next = body_length;
    device_id_next   = device_id;
    error_byte_next  = error_byte;
    running_sum_next = running_sum;
    last_c           = 1'b0;
    bad_c            = 1'b0;

    // Start of frame: drop what the previous frame left
    if (position == '0) begin
      body_length_next = '0;
      device_id_next   = '0;
      error_byte_next  = '0;
      running_sum_next = '0;
    end

    if (position == POS_ID) begin
      device_id_next   = s_axis_tdata;
      running_sum_next = running_sum + s_axis_tdata;
    end else if (position == POS_LENGTH) begin
      body_length_next = s_axis_tdata;
      if (s_axis_tdata == '0) begin
        // empty body: the length byte doubles as the checksum
        last_c = 1'b1;
        bad_c  = (~running_sum) != s_axis_tdata;
      end else begin
        running_sum_next = running_sum + s_axis_tdata;
      end
    end else if (position >= FIXED_LEN) begin
      if (position == FIXED_LEN) begin
        error_byte_next = s_axis_tdata;
      end
      if (position == last_pos) begin
        last_c = 1'b1;
        bad_c  = (~running_sum) != s_axis_tdata;
      end else begin
        running_sum_next = running_sum + s_axis_tdata;
      end
    end

    position_next = last_c ? '0 : position + 9'd1;
    flags_c       = last_c ? (error_byte_next | (bad_c ? CHECKSUM_FLAG : '0)) : '0;
    id_c          = (position >= POS_ID) ? device_id_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      body_length <= '0;
      device_id   <= '0;
      error_byte  <= '0;
      running_sum <= '0;
    end else if (s_fire) begin
      position    <= position_next;
      body_length <= body_length_next;
      device_id   <= device_id_next;
      error_byte  <= error_byte_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result payload: hold while the master side stalls
  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_byte  <= s_axis_tdata;
      out_index <= position;
      out_id    <= id_c;
      out_flags <= flags_c;
      out_last  <= last_c;
      out_bad   <= bad_c;
    end
  end

  assign m_axis_tdata = {{(TDATA_W - PAD_LSB){1'b0}}, out_flags, out_id, out_index, out_byte};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_bad;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= {1'b0, 8'hff} + FIXED_LEN - 9'd1)
    else $error("frame position beyond the longest frame");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    s_fire && last_c |=> position == '0)
    else $error("position did not return to start after last byte");

  a_bad_sets_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tlast && m_axis_tdata[FLAGS_LSB + 4])
    else $error("checksum mismatch without last or status flag");

  a_flags_only_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[PAD_LSB-1:FLAGS_LSB] == '0 && !m_axis_tuser[0])
    else $error("status reported on a byte that does not end the frame");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

endmodule
